[rtl/hmuc_pkg.sv]
// shared types and constants for the heating mode ui controller
`default_nettype none

package hmuc_pkg;

  localparam logic [11:0] MINUTES_PER_DAY = 12'd1440;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ECO_BIAS          = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAKE_DURATION     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OCCUPANCY_TIMEOUT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLI_TIMEOUT       = 2'd3;

  localparam logic       ECO_BIAS_RST          = 1'b1;
  localparam logic [7:0] BAKE_DURATION_RST     = 8'd30;
  localparam logic [7:0] OCCUPANCY_TIMEOUT_RST = 8'd30;
  localparam logic [6:0] CLI_TIMEOUT_RST       = 7'd60;

  localparam logic [7:0]  ECO_LENGTH     = 8'd60;
  localparam logic [7:0]  COMFORT_LENGTH = 8'd120;

  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_SCHED = 1'b1;

  localparam logic [1:0] MODE_FROST = 2'd0;
  localparam logic [1:0] MODE_WARM  = 2'd1;
  localparam logic [1:0] MODE_BAKE  = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic        eco_bias;
    logic [7:0]  bake_duration;
    logic [7:0]  occupancy_timeout;
    logic [6:0]  cli_timeout;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  second;
    logic        mode_pressed;
    logic        learn_pressed;
    logic        room_dark;
    logic [6:0]  valve_percent;
    logic [10:0] minute_of_day;
    logic [10:0] sched_on_minute;
    logic [10:0] sched_off_minute;
  } item_t;

  typedef struct packed {
    logic        status_changed;
    logic [1:0]  flash_count;
    logic [1:0]  heat_mode;
    logic        occupied;
    logic        recently_occupied;
    logic        cli_active;
    logic [1:0]  schedule_action;
    logic [10:0] schedule_start;
    logic [7:0]  schedule_length;
    logic        learn_led_on;
  } result_t;

endpackage

`default_nettype wire

[rtl/heating_mode_ui_controller_core.sv]
// top level: input register, mode update logic and result register
`default_nettype none

// Mode controller for a radiator valve. Each beat on the slave side is either a two-second
// ui tick or a schedule check (tuser) and gives exactly one result beat on the master side.
// The block takes one beat every clock cycle unless the master side stalls; each beat passes
// first through the input register and then through the result register, with the whole
// state update done in a single pass between them. Either register holds its beat while
// the next side stalls. Configuration writes take effect on the next clock edge and should
// only be made while no beat is in flight.
module heating_mode_ui_controller_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [hmuc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hmuc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // second, mode_pressed, learn_pressed, room_dark, valve_percent, minute_of_day,
  // sched_on_minute, sched_off_minute, zero fill
  input  wire logic [55:0]                       s_axis_tdata,
  // req_type
  input  wire logic                              s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status_changed, flash_count, heat_mode, occupied, recently_occupied, cli_active,
  // schedule_action, schedule_start, schedule_length, learn_led_on, zero fill
  output      logic [31:0]                       m_axis_tdata
);

  hmuc_pkg::cfg_t    cfg;
  hmuc_pkg::item_t   item_q;
  hmuc_pkg::result_t result, res_q;
  logic              in_valid, out_valid, advance;

  hmuc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hmuc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req_type         <= s_axis_tuser;
      item_q.second           <= s_axis_tdata[5:0];
      item_q.mode_pressed     <= s_axis_tdata[6];
      item_q.learn_pressed    <= s_axis_tdata[7];
      item_q.room_dark        <= s_axis_tdata[8];
      item_q.valve_percent    <= s_axis_tdata[15:9];
      item_q.minute_of_day    <= s_axis_tdata[26:16];
      item_q.sched_on_minute  <= s_axis_tdata[37:27];
      item_q.sched_off_minute <= s_axis_tdata[48:38];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00,
                          res_q.learn_led_on,
                          res_q.schedule_length,
                          res_q.schedule_start,
                          res_q.schedule_action,
                          res_q.cli_active,
                          res_q.recently_occupied,
                          res_q.occupied,
                          res_q.heat_mode,
                          res_q.flash_count,
                          res_q.status_changed};

`ifndef SYNTHESIS
  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  a_input_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_axis_tready) |=> in_valid)
    else $error("input beat lost while result stalled");

  a_action_implies_learn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.schedule_action != hmuc_pkg::ACT_NONE)
      |-> (res_q.learn_led_on && res_q.status_changed))
    else $error("schedule action without learn press");

  a_set_has_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.schedule_action == hmuc_pkg::ACT_SET)
      |-> (res_q.schedule_length == hmuc_pkg::ECO_LENGTH
           || res_q.schedule_length == hmuc_pkg::COMFORT_LENGTH))
    else $error("learned schedule length invalid");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat did not reach result register");
`endif

endmodule

`default_nettype wire

[rtl/hmuc_cfg.sv]
// configuration register file
`default_nettype none

module hmuc_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [hmuc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hmuc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hmuc_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eco_bias          <= hmuc_pkg::ECO_BIAS_RST;
      cfg.bake_duration     <= hmuc_pkg::BAKE_DURATION_RST;
      cfg.occupancy_timeout <= hmuc_pkg::OCCUPANCY_TIMEOUT_RST;
      cfg.cli_timeout       <= hmuc_pkg::CLI_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hmuc_pkg::REG_ECO_BIAS:          cfg.eco_bias          <= cfg_data[0];
        hmuc_pkg::REG_BAKE_DURATION:     cfg.bake_duration     <= cfg_data[7:0];
        hmuc_pkg::REG_OCCUPANCY_TIMEOUT: cfg.occupancy_timeout <= cfg_data[7:0];
        hmuc_pkg::REG_CLI_TIMEOUT:       cfg.cli_timeout       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/hmuc_core.sv]
// mode state registers and single-pass update logic
`default_nettype none

module hmuc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire hmuc_pkg::item_t item,
  input  wire hmuc_pkg::cfg_t  cfg,
  output hmuc_pkg::result_t    result
);

  logic       warm_flag, warm_flag_next;
  logic [7:0] bake_left, bake_left_next;
  logic [7:0] occupancy_left, occupancy_left_next;
  logic [6:0] cli_left, cli_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_flag      <= 1'b0;
      bake_left      <= 8'd0;
      occupancy_left <= 8'd0;
      cli_left       <= hmuc_pkg::CLI_TIMEOUT_RST;
    end else if (fire) begin
      warm_flag      <= warm_flag_next;
      bake_left      <= bake_left_next;
      occupancy_left <= occupancy_left_next;
      cli_left       <= cli_left_next;
    end
  end

  logic [11:0] msm_ext, on_ext, off_ext, wind, start_wide;
  logic [7:0]  length;

  always_comb begin
    msm_ext = {1'b0, item.minute_of_day};
    on_ext  = {1'b0, item.sched_on_minute};
    off_ext = {1'b0, item.sched_off_minute};
    length  = cfg.eco_bias ? hmuc_pkg::ECO_LENGTH : hmuc_pkg::COMFORT_LENGTH;
    wind    = {6'd0, length[7:2]};
    if (msm_ext >= wind) begin
      start_wide = msm_ext - wind;
    end else begin
      start_wide = msm_ext + hmuc_pkg::MINUTES_PER_DAY - wind;
    end
  end

  always_comb begin
    warm_flag_next      = warm_flag;
    bake_left_next      = bake_left;
    occupancy_left_next = occupancy_left;
    cli_left_next       = cli_left;
    result              = '0;

    if (item.req_type == hmuc_pkg::REQ_SCHED) begin
      if (off_ext < hmuc_pkg::MINUTES_PER_DAY && msm_ext == off_ext) begin
        warm_flag_next = 1'b0;
      end else if (on_ext < hmuc_pkg::MINUTES_PER_DAY && msm_ext == on_ext) begin
        warm_flag_next = 1'b1;
      end
    end else begin
      // minute boundary
      if (item.second == 6'd0) begin
        if (bake_left_next != 8'd0) bake_left_next = bake_left_next - 8'd1;
        if (occupancy_left_next != 8'd0) occupancy_left_next = occupancy_left_next - 8'd1;
      end
      cli_left_next = (cli_left > 7'd2) ? cli_left - 7'd2 : 7'd0;

      if (item.mode_pressed) begin
        result.status_changed = 1'b1;
        cli_left_next = cfg.cli_timeout;
        if (!warm_flag) begin
          warm_flag_next      = 1'b1;
          occupancy_left_next = cfg.occupancy_timeout;
          bake_left_next      = 8'd0;
          result.flash_count  = 2'd2;
        end else if (bake_left_next == 8'd0) begin
          bake_left_next      = cfg.bake_duration;
          occupancy_left_next = cfg.occupancy_timeout;
          result.flash_count  = 2'd3;
        end else begin
          warm_flag_next     = 1'b0;
          result.flash_count = 2'd1;
        end
      end else if (warm_flag) begin
        if (!item.room_dark) begin
          if (item.valve_percent == 7'd0) begin
            result.flash_count = 2'd1;
          end else if (bake_left_next != 8'd0) begin
            result.flash_count = 2'd3;
          end else begin
            result.flash_count = 2'd2;
          end
        end
      end else if (item.second[2:1] == 2'b00 && !item.room_dark
                   && item.valve_percent != 7'd0) begin
        result.flash_count = 2'd2;
      end

      if (item.learn_pressed) begin
        result.status_changed = 1'b1;
        result.learn_led_on   = 1'b1;
        occupancy_left_next   = cfg.occupancy_timeout;
        if (warm_flag_next) begin
          result.schedule_action = hmuc_pkg::ACT_SET;
          result.schedule_start  = start_wide[10:0];
          result.schedule_length = length;
        end else begin
          result.schedule_action = hmuc_pkg::ACT_CLEAR;
        end
      end
    end

    if (!warm_flag_next) begin
      result.heat_mode = hmuc_pkg::MODE_FROST;
    end else if (bake_left_next != 8'd0) begin
      result.heat_mode = hmuc_pkg::MODE_BAKE;
    end else begin
      result.heat_mode = hmuc_pkg::MODE_WARM;
    end
    result.occupied          = occupancy_left_next != 8'd0;
    result.recently_occupied = occupancy_left_next > {1'b0, cfg.occupancy_timeout[7:1]};
    result.cli_active        = cli_left_next != 7'd0;
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for the heating mode ui controller: random and directed beats against a predictor
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_we = 1'b0;
  logic [hmuc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hmuc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // second, mode_pressed, learn_pressed, room_dark, valve_percent, minute_of_day,
  // sched_on_minute, sched_off_minute, zero fill
  logic [55:0] s_axis_tdata = '0;
  // req_type
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status_changed, flash_count, heat_mode, occupied, recently_occupied, cli_active,
  // schedule_action, schedule_start, schedule_length, learn_led_on, zero fill
  logic [31:0] m_axis_tdata;

  heating_mode_ui_controller_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted controller state and register shadow
  logic       warm_on = 1'b0;
  logic [7:0] bake_left = 8'd0;
  logic [7:0] occ_left = 8'd0;
  logic [6:0] cli_left = hmuc_pkg::CLI_TIMEOUT_RST;
  logic       eco_sel = hmuc_pkg::ECO_BIAS_RST;
  logic [7:0] bake_minutes = hmuc_pkg::BAKE_DURATION_RST;
  logic [7:0] occ_minutes = hmuc_pkg::OCCUPANCY_TIMEOUT_RST;
  logic [6:0] cli_seconds = hmuc_pkg::CLI_TIMEOUT_RST;

  hmuc_pkg::item_t   pending_items[$];
  hmuc_pkg::result_t due_results[$];
  hmuc_pkg::item_t   in_flight;
  int                errors = 0;
  int                results_seen = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  bit                src_steady = 1'b0;
  bit                sink_steady = 1'b0;

  function automatic hmuc_pkg::result_t mode_step(hmuc_pkg::item_t it);
    hmuc_pkg::result_t r;
    int                wind;
    int                start;
    r = '0;
    if (it.req_type == hmuc_pkg::REQ_SCHED) begin
      if (it.sched_off_minute < hmuc_pkg::MINUTES_PER_DAY
          && it.minute_of_day == it.sched_off_minute)
        warm_on = 1'b0;
      else if (it.sched_on_minute < hmuc_pkg::MINUTES_PER_DAY
               && it.minute_of_day == it.sched_on_minute)
        warm_on = 1'b1;
    end else begin
      if (it.second == 6'd0) begin
        if (bake_left != 8'd0) bake_left = bake_left - 8'd1;
        if (occ_left != 8'd0) occ_left = occ_left - 8'd1;
      end
      cli_left = (cli_left > 7'd2) ? cli_left - 7'd2 : 7'd0;
      if (it.mode_pressed) begin
        r.status_changed = 1'b1;
        cli_left = cli_seconds;
        if (!warm_on) begin
          warm_on = 1'b1;
          occ_left = occ_minutes;
          bake_left = 8'd0;
          r.flash_count = 2'd2;
        end else if (bake_left == 8'd0) begin
          bake_left = bake_minutes;
          occ_left = occ_minutes;
          r.flash_count = 2'd3;
        end else begin
          warm_on = 1'b0;
          r.flash_count = 2'd1;
        end
      end else if (warm_on) begin
        if (!it.room_dark)
          r.flash_count = (it.valve_percent == 7'd0) ? 2'd1 : (bake_left != 8'd0) ? 2'd3 : 2'd2;
      end else if ((it.second & 6'd6) == 6'd0 && !it.room_dark && it.valve_percent != 7'd0) begin
        r.flash_count = 2'd2;
      end
      if (it.learn_pressed) begin
        r.status_changed = 1'b1;
        r.learn_led_on = 1'b1;
        occ_left = occ_minutes;
        if (warm_on) begin
          r.schedule_length = eco_sel ? hmuc_pkg::ECO_LENGTH : hmuc_pkg::COMFORT_LENGTH;
          wind = int'(r.schedule_length) >> 2;
          if (int'(it.minute_of_day) >= wind) start = int'(it.minute_of_day) - wind;
          else start = int'(it.minute_of_day) + int'(hmuc_pkg::MINUTES_PER_DAY) - wind;
          r.schedule_start = start[10:0];
          r.schedule_action = hmuc_pkg::ACT_SET;
        end else begin
          r.schedule_action = hmuc_pkg::ACT_CLEAR;
        end
      end
    end
    if (!warm_on) r.heat_mode = hmuc_pkg::MODE_FROST;
    else r.heat_mode = (bake_left != 8'd0) ? hmuc_pkg::MODE_BAKE : hmuc_pkg::MODE_WARM;
    r.occupied = occ_left != 8'd0;
    r.recently_occupied = occ_left > (occ_minutes >> 1);
    r.cli_active = cli_left != 7'd0;
    return r;
  endfunction

  function automatic hmuc_pkg::item_t mk_item(logic req, int sec, logic mode, logic learn,
                                              logic dark, int valve, int minute, int on_min,
                                              int off_min);
    hmuc_pkg::item_t it;
    it.req_type = req;
    it.second = sec[5:0];
    it.mode_pressed = mode;
    it.learn_pressed = learn;
    it.room_dark = dark;
    it.valve_percent = valve[6:0];
    it.minute_of_day = minute[10:0];
    it.sched_on_minute = on_min[10:0];
    it.sched_off_minute = off_min[10:0];
    return it;
  endfunction

  function automatic logic [10:0] pick_sched(logic [10:0] minute);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return minute;
    if (roll < 60) return 11'($urandom_range(2047, 1440));
    return 11'($urandom_range(2047));
  endfunction

  function automatic hmuc_pkg::item_t rand_item();
    hmuc_pkg::item_t it;
    int unsigned     roll;
    it.req_type = ($urandom_range(99) < 20) ? hmuc_pkg::REQ_SCHED : hmuc_pkg::REQ_TICK;
    roll = $urandom_range(99);
    if (roll < 35) it.second = 6'd0;
    else if (roll < 85) it.second = 6'($urandom_range(29) * 2);
    else it.second = 6'($urandom_range(63));
    it.mode_pressed = $urandom_range(99) < 12;
    it.learn_pressed = $urandom_range(99) < 8;
    it.room_dark = $urandom_range(1);
    it.valve_percent = ($urandom_range(99) < 30) ? 7'd0 : 7'($urandom_range(127));
    roll = $urandom_range(99);
    if (roll < 15) it.minute_of_day = 11'($urandom_range(40));
    else if (roll < 90) it.minute_of_day = 11'($urandom_range(1439));
    else it.minute_of_day = 11'($urandom_range(2047));
    it.sched_on_minute = pick_sched(it.minute_of_day);
    it.sched_off_minute = pick_sched(it.minute_of_day);
    return it;
  endfunction

  always @(posedge clk) begin : source
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(mode_step(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && (src_steady || $urandom_range(99) >= 18)) begin
          in_flight = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= in_flight.req_type;
          s_axis_tdata <= {7'd0, in_flight.sched_off_minute, in_flight.sched_on_minute,
                           in_flight.minute_of_day, in_flight.valve_percent, in_flight.room_dark,
                           in_flight.learn_pressed, in_flight.mode_pressed, in_flight.second};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : sink
    hmuc_pkg::result_t want;
    logic [31:0]       got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status_changed", want.status_changed, got[0]);
          check_field("flash_count", want.flash_count, got[2:1]);
          check_field("heat_mode", want.heat_mode, got[4:3]);
          check_field("occupied", want.occupied, got[5]);
          check_field("recently_occupied", want.recently_occupied, got[6]);
          check_field("cli_active", want.cli_active, got[7]);
          check_field("schedule_action", want.schedule_action, got[9:8]);
          check_field("schedule_start", want.schedule_start, got[20:10]);
          check_field("schedule_length", want.schedule_length, got[28:21]);
          check_field("learn_led_on", want.learn_led_on, got[29]);
        end
        results_seen++;
        // long back-pressure so the block fills up and stalls its input
        if (results_seen == 500 && !hold_done) begin
          hold_left = 300;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= sink_steady || $urandom_range(99) >= 18;
      end
    end
  end

  // looks just after each edge so that updates made at the edge are seen
  task automatic drain();
    @(posedge clk);
    #1;
    while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0
           || m_axis_tvalid) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [hmuc_pkg::CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[hmuc_pkg::CFG_DATA_W-1:0];
    case (idx)
      hmuc_pkg::REG_ECO_BIAS:          eco_sel = value[0];
      hmuc_pkg::REG_BAKE_DURATION:     bake_minutes = value[7:0];
      hmuc_pkg::REG_OCCUPANCY_TIMEOUT: occ_minutes = value[7:0];
      hmuc_pkg::REG_CLI_TIMEOUT:       cli_seconds = value[6:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int eco, int bake, int occ, int cli, bit steady);
    write_reg(hmuc_pkg::REG_ECO_BIAS, eco);
    write_reg(hmuc_pkg::REG_BAKE_DURATION, bake);
    write_reg(hmuc_pkg::REG_OCCUPANCY_TIMEOUT, occ);
    write_reg(hmuc_pkg::REG_CLI_TIMEOUT, cli);
    @(posedge clk);
    cfg_we <= 1'b0;
    src_steady = steady;
    sink_steady = steady;
    repeat (204) pending_items.push_back(rand_item());
    drain();
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // frost flashes and the fourth-tick rule
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 0, 0, 0, 0, 100, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 2, 0, 0, 0, 100, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 8, 0, 0, 0, 127, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 63, 0, 0, 0, 1, 10, 0, 0));
    // warm, learn with wrap and with out-of-range minute, bake, back to frost
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 4, 1, 0, 0, 50, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 6, 0, 0, 0, 0, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 10, 0, 0, 1, 80, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 12, 0, 1, 0, 80, 5, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 14, 0, 1, 0, 80, 2047, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 16, 1, 0, 0, 80, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 18, 0, 0, 0, 1, 10, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 20, 1, 0, 0, 1, 10, 0, 0));
    // schedule checks: on match brings back bake, off match, out-of-day never matches
    pending_items.push_back(mk_item(hmuc_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 100, 100, 2047));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 200, 0, 200));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 1500, 1500, 1500));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 22, 0, 1, 0, 0, 300, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 0, 1, 1, 1, 0, 0, 0, 0));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 700, 700, 700));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_TICK, 63, 1, 1, 1, 127, 2047, 2047, 2047));
    pending_items.push_back(mk_item(hmuc_pkg::REQ_SCHED, 63, 1, 1, 1, 127, 1439, 1439, 2047));
    drain();

    run_phase(0, 255, 255, 127, 1'b0);
    run_phase(1, 1, 1, 0, 1'b0);
    run_phase(0, 0, 0, 1, 1'b1);
    run_phase($urandom_range(1), $urandom_range(255, 1), $urandom_range(255, 1),
              $urandom_range(127), 1'b0);
    run_phase(1, 2, 3, 2, 1'b0);
    run_phase($urandom_range(1), $urandom_range(40), $urandom_range(40),
              $urandom_range(127), 1'b0);
    run_phase(0, 120, 60, 30, 1'b0);
    run_phase(1, 30, 30, 60, 1'b0);

    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/hmuc_pkg.sv
rtl/hmuc_cfg.sv
rtl/hmuc_core.sv
rtl/heating_mode_ui_controller_core.sv
tb/tb.sv
